@@ hdl/ps2_mouse_packet_tracker_assert.svh @@
// assertion macros used by the tracker decoder
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// condition in the same cycle
`define PS2MT_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ps2mt assertion failed");

// expression checked in the cycle after the condition
`define PS2MT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ps2mt assertion failed");

`endif

@@ hdl/ps2mt_pkg.sv @@
// types, constants and helper functions of the mouse packet tracker
package ps2mt_pkg;

    localparam logic       MODE_RX    = 1'b0;
    localparam logic       MODE_CMD   = 1'b1;

    localparam logic [1:0] CFG_X_GAIN    = 2'd0;
    localparam logic [1:0] CFG_Y_GAIN    = 2'd1;
    localparam logic [1:0] CFG_REPORT_EN = 2'd2;

    localparam logic [7:0]  ACK_BYTE     = 8'hFA;
    localparam logic [3:0]  PENDING_MAX  = 4'd15;
    localparam logic [1:0]  LAST_INDEX   = 2'd2;
    localparam logic [19:0] POS_MAX      = 20'd999999;
    localparam logic [15:0] GAIN_RESET   = 16'd400;

    typedef struct packed {
        logic [15:0] x_gain;
        logic [15:0] y_gain;
        logic        report_enable;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic [19:0] x_position;
        logic [19:0] y_position;
        logic [2:0]  buttons;
    } dec_out_t;

    // zero byte is zero movement regardless of sign
    function automatic logic signed [8:0] delta_of(input logic [7:0] b, input logic sign);
        logic signed [8:0] d;
        begin
            if (b == 8'd0)
            begin
                d = 9'sd0;
            end
            else
            begin
                d = signed'({sign, b});
            end
            return d;
        end
    endfunction

    function automatic logic [19:0] clamp_pos(input logic signed [26:0] v);
        logic [19:0] r;
        begin
            if (v < 27'sd0)
            begin
                r = 20'd0;
            end
            else if (v > signed'({7'd0, POS_MAX}))
            begin
                r = POS_MAX;
            end
            else
            begin
                r = v[19:0];
            end
            return r;
        end
    endfunction

endpackage

@@ hdl/ps2mt_if.sv @@
// handshake channels of the mouse packet tracker

interface ps2mt_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface ps2mt_result_if;
    logic        valid;
    logic        ready;
    logic [19:0] x_position;
    logic [19:0] y_position;
    logic [2:0]  buttons;

    modport source (output valid, output x_position, output y_position, output buttons,
                    input ready);
    modport sink   (input valid, input x_position, input y_position, input buttons,
                    output ready);
endinterface

interface ps2mt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ps2mt_cfg_regs.sv @@
// configuration registers: gains and report enable
module ps2mt_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    ps2mt_cfg_if.sink       cfg,
    output ps2mt_pkg::cfg_t cfg_out
);
    import ps2mt_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_gain        <= GAIN_RESET;
            cfg_reg.y_gain        <= GAIN_RESET;
            cfg_reg.report_enable <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_X_GAIN:    cfg_reg.x_gain        <= cfg.data;
                CFG_Y_GAIN:    cfg_reg.y_gain        <= cfg.data;
                CFG_REPORT_EN: cfg_reg.report_enable <= cfg.data[0];
                default:       ;
            endcase
        end
    end

endmodule

@@ hdl/ps2mt_decoder.sv @@
// ack filtering, packet assembly and position accumulation
module ps2mt_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                mode,
    input  logic [7:0]          rx_byte,
    input  ps2mt_pkg::cfg_t     cfg,
    output ps2mt_pkg::dec_out_t dec
);
    import ps2mt_pkg::*;

    `include "ps2_mouse_packet_tracker_assert.svh"

    logic [1:0]  byte_index_reg, byte_index_next;
    logic [3:0]  acks_reg, acks_next;
    logic [19:0] x_accum_reg, x_accum_next;
    logic [19:0] y_accum_reg, y_accum_next;
    logic [7:0]  head_reg;
    logic [7:0]  dx_byte_reg;

    logic               is_ack;
    logic               is_data;
    logic               complete;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [25:0] prod_x;
    logic signed [25:0] prod_y;
    logic signed [26:0] sum_x;
    logic signed [26:0] sum_y;
    logic [19:0]        new_x;
    logic [19:0]        new_y;

    always_comb
    begin
        is_ack   = (mode == MODE_RX) && (acks_reg != 4'd0) && (rx_byte == ACK_BYTE);
        is_data  = (mode == MODE_RX) && !is_ack;
        complete = is_data && (byte_index_reg >= LAST_INDEX);

        dx     = delta_of(dx_byte_reg, head_reg[4]);
        dy     = delta_of(rx_byte, head_reg[5]);
        prod_x = 26'(signed'({1'b0, cfg.x_gain})) * 26'(dx);
        prod_y = 26'(signed'({1'b0, cfg.y_gain})) * 26'(dy);
        sum_x  = signed'({7'd0, x_accum_reg}) + 27'(prod_x);
        sum_y  = signed'({7'd0, y_accum_reg}) - 27'(prod_y);
        new_x  = clamp_pos(sum_x);
        new_y  = clamp_pos(sum_y);

        byte_index_next = byte_index_reg;
        acks_next       = acks_reg;
        x_accum_next    = x_accum_reg;
        y_accum_next    = y_accum_reg;

        if (mode == MODE_CMD)
        begin
            if (acks_reg != PENDING_MAX)
            begin
                acks_next = acks_reg + 4'd1;
            end
        end
        else if (is_ack)
        begin
            acks_next = acks_reg - 4'd1;
        end
        else
        begin
            acks_next = 4'd0;
            if (complete)
            begin
                byte_index_next = 2'd0;
                x_accum_next    = new_x;
                y_accum_next    = new_y;
            end
            else
            begin
                byte_index_next = byte_index_reg + 2'd1;
            end
        end

        dec.emit       = complete && cfg.report_enable;
        dec.x_position = new_x;
        dec.y_position = new_y;
        dec.buttons    = head_reg[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 2'd0;
            acks_reg       <= 4'd0;
            x_accum_reg    <= 20'd0;
            y_accum_reg    <= 20'd0;
        end
        else if (step)
        begin
            byte_index_reg <= byte_index_next;
            acks_reg       <= acks_next;
            x_accum_reg    <= x_accum_next;
            y_accum_reg    <= y_accum_next;
        end
    end

    // packet bytes held until the third byte arrives
    always_ff @(posedge clk)
    begin
        if (step && is_data && !complete)
        begin
            if (byte_index_reg[0] == 1'b0)
            begin
                head_reg <= rx_byte;
            end
            else
            begin
                dx_byte_reg <= rx_byte;
            end
        end
    end

    `PS2MT_ASSERT_SAME(a_index_range, clk, rst_n, 1'b1, byte_index_reg != 2'd3)
    `PS2MT_ASSERT_SAME(a_emit_on_last, clk, rst_n, dec.emit,
        (mode == MODE_RX) && (byte_index_reg == LAST_INDEX) && cfg.report_enable)
    `PS2MT_ASSERT_NEXT(a_cmd_counts, clk, rst_n,
        step && (mode == MODE_CMD) && (acks_reg != PENDING_MAX),
        acks_reg == $past(acks_reg) + 4'd1)
    `PS2MT_ASSERT_NEXT(a_packet_wraps, clk, rst_n, step && complete,
        (byte_index_reg == 2'd0) && (acks_reg == 4'd0))

endmodule

@@ hdl/ps2_mouse_packet_tracker.sv @@
// top level of the mouse packet tracker
// Takes one item per clock: a byte from the mouse or a command-sent notice.
// Each item passes an input register, then decode, ack filtering and a single
// gain multiply, add and clamp per axis that updates the position state; the
// result of a completed packet is then captured in the result register.
// Sustained rate is one item per cycle; the only stall is a reported
// packet-completing item meeting a result register whose item has not been taken.
module ps2_mouse_packet_tracker (
    input  logic            clk,
    input  logic            rst_n,
    ps2mt_item_if.sink      item,
    ps2mt_result_if.source  result,
    ps2mt_cfg_if.sink       cfg
);
    import ps2mt_pkg::*;

    cfg_t     cfg_val;
    dec_out_t dec;

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    logic        out_valid_reg;
    logic [19:0] out_x_reg;
    logic [19:0] out_y_reg;
    logic [2:0]  out_buttons_reg;

    logic out_free;
    logic advance;

    ps2mt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    ps2mt_decoder u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .mode    (in_mode_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_val),
        .dec     (dec)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && (!dec.emit || out_free);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_mode_reg <= item.mode;
            in_byte_reg <= item.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && dec.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.emit)
        begin
            out_x_reg       <= dec.x_position;
            out_y_reg       <= dec.y_position;
            out_buttons_reg <= dec.buttons;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.x_position = out_x_reg;
    assign result.y_position = out_y_reg;
    assign result.buttons    = out_buttons_reg;

endmodule

@@ tb/sv/ps2_mouse_packet_tracker_test.sv @@
// testbench for the mouse packet tracker: byte stream stimulus, position prediction, result checks
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_test;

    import ps2mt_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } mouse_item_t;

    typedef struct packed {
        logic [19:0] x_position;
        logic [19:0] y_position;
        logic [2:0]  buttons;
    } position_report_t;

    logic clk = 1'b0;
    logic rst_n;

    ps2mt_item_if   item_ch();
    ps2mt_result_if result_ch();
    ps2mt_cfg_if    cfg_ch();

    ps2_mouse_packet_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // tracker state as predicted
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic        reporting;
    logic [7:0]  held_bytes [2];
    logic [1:0]  byte_count;
    logic [3:0]  acks_pending;
    logic [19:0] x_accum;
    logic [19:0] y_accum;

    mouse_item_t      pending_items [$];
    position_report_t expected_reports [$];
    mouse_item_t      head_item;
    position_report_t seen_report;
    position_report_t want_report;

    int queued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_style    = 0;
    int stall_tick     = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic int movement(input logic [7:0] b, input logic negative);
        if (b == 8'h00)
        begin
            return 0;
        end
        return negative ? int'(b) - 256 : int'(b);
    endfunction

    function automatic logic [19:0] bound_position(input longint v);
        if (v < 0)
        begin
            return 20'd0;
        end
        if (v > longint'(POS_MAX))
        begin
            return POS_MAX;
        end
        return v[19:0];
    endfunction

    function automatic void track_item(input logic mode, input logic [7:0] b);
        int               dx;
        int               dy;
        longint           nx;
        longint           ny;
        position_report_t rep;
        if (mode == MODE_CMD)
        begin
            if (acks_pending < PENDING_MAX)
            begin
                acks_pending++;
            end
            return;
        end
        if (acks_pending != 4'd0)
        begin
            if (b == ACK_BYTE)
            begin
                acks_pending--;
                return;
            end
            acks_pending = 4'd0;
        end
        if (byte_count < LAST_INDEX)
        begin
            held_bytes[byte_count] = b;
            byte_count++;
            return;
        end
        byte_count = 2'd0;
        dx = movement(held_bytes[1], held_bytes[0][4]);
        dy = movement(b, held_bytes[0][5]);
        nx = longint'(x_accum) + longint'(gain_x) * longint'(dx);
        ny = longint'(y_accum) - longint'(gain_y) * longint'(dy);
        x_accum = bound_position(nx);
        y_accum = bound_position(ny);
        if (reporting)
        begin
            rep.x_position = x_accum;
            rep.y_position = y_accum;
            rep.buttons    = held_bytes[0][2:0];
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic void push_item(input logic mode, input logic [7:0] b);
        mouse_item_t it;
        it.mode    = mode;
        it.rx_byte = b;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    function automatic logic [7:0] random_delta();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 8'h01;
                    1: return 8'h7F;
                    2: return 8'h80;
                    default: return 8'hFF;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_packet(input logic [7:0] head, input logic [7:0] dx,
                                       input logic [7:0] dy);
        push_item(MODE_RX, head);
        push_item(MODE_RX, dx);
        push_item(MODE_RX, dy);
    endfunction

    // mostly whole packets and command/ack exchanges, some stray and cut-off bytes
    function automatic void add_traffic(input int count);
        int target;
        int cmds;
        int acks;
        target = queued_count + count;
        while (queued_count < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    add_packet(8'($urandom), random_delta(), random_delta());
                6, 7:
                begin
                    cmds = $urandom_range(1, 18);
                    acks = $urandom_range(0, cmds + 1);
                    repeat (cmds) push_item(MODE_CMD, 8'($urandom));
                    repeat (acks) push_item(MODE_RX, ACK_BYTE);
                end
                8:
                    push_item(1'($urandom), 8'($urandom));
                default:
                begin
                    push_item(MODE_RX, 8'($urandom));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        push_item(MODE_RX, random_delta());
                    end
                end
            endcase
        end
    endfunction

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_X_GAIN:    gain_x = value;
            CFG_Y_GAIN:    gain_y = value;
            CFG_REPORT_EN: reporting = value[0];
            default: ;
        endcase
    endtask

    task automatic settle_then_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                track_item(item_ch.mode, item_ch.rx_byte);
                accepted_count++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left == 0 && pending_items.size() > 0)
                begin
                    head_item = pending_items.pop_front();
                    item_ch.valid   <= 1'b1;
                    item_ch.mode    <= head_item.mode;
                    item_ch.rx_byte <= head_item.rx_byte;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    item_ch.valid   <= 1'b0;
                    item_ch.mode    <= 1'($urandom);
                    item_ch.rx_byte <= 8'($urandom);
                end
            end
        end
    end

    // receiver: checks each result, stalls on a per-phase pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen_report.x_position = result_ch.x_position;
                seen_report.y_position = result_ch.y_position;
                seen_report.buttons    = result_ch.buttons;
                if (expected_reports.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result x=%0d y=%0d buttons=%0d",
                                              seen_report.x_position, seen_report.y_position,
                                              seen_report.buttons));
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (seen_report.x_position !== want_report.x_position)
                    begin
                        report_mismatch($sformatf("x_position %0d, expected %0d",
                                                  seen_report.x_position,
                                                  want_report.x_position));
                    end
                    if (seen_report.y_position !== want_report.y_position)
                    begin
                        report_mismatch($sformatf("y_position %0d, expected %0d",
                                                  seen_report.y_position,
                                                  want_report.y_position));
                    end
                    if (seen_report.buttons !== want_report.buttons)
                    begin
                        report_mismatch($sformatf("buttons %0d, expected %0d",
                                                  seen_report.buttons, want_report.buttons));
                    end
                end
            end
            stall_tick++;
            case (stall_style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= 1'($urandom);
                2:       result_ch.ready <= (stall_tick % 9) >= 4;
                default: result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ps2_mouse_packet_tracker_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = MODE_RX;
        item_ch.rx_byte = 8'h00;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_X_GAIN;
        cfg_ch.data     = 16'h0000;
        gain_x          = GAIN_RESET;
        gain_y          = GAIN_RESET;
        reporting       = 1'b0;
        byte_count      = 2'd0;
        acks_pending    = 4'd0;
        x_accum         = 20'd0;
        y_accum         = 20'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_register(CFG_REPORT_EN, 16'h0001);
        stall_style = 0;
        // full movement with all buttons, then zero bytes whose sign bits are set
        add_packet(8'h07, 8'h7F, 8'h80);
        add_packet(8'h30, 8'h00, 8'h00);
        // large negative x drives the position below zero
        add_packet(8'h10, 8'h01, 8'hFF);
        // ack swallowed; the byte of a command notice is ignored
        push_item(MODE_CMD, 8'hFF);
        push_item(MODE_RX, ACK_BYTE);
        // ack byte with nothing pending is packet data
        add_packet(ACK_BYTE, 8'h05, 8'h05);
        // non-ack byte drops the pending acks and starts a packet
        push_item(MODE_CMD, 8'h00);
        push_item(MODE_CMD, 8'hAA);
        add_packet(8'h08, 8'h00, 8'h00);
        push_item(MODE_CMD, ACK_BYTE);
        push_item(MODE_RX, ACK_BYTE);
        add_packet(ACK_BYTE, 8'h7F, 8'h7F);
        add_traffic(300);
        settle_then_idle();

        write_register(CFG_X_GAIN, 16'hFFFF);
        write_register(CFG_Y_GAIN, 16'hFFFF);
        stall_style = 1;
        add_traffic(125);
        // sender holds off until every pending result is out
        wait_drained();
        add_traffic(125);
        settle_then_idle();

        write_register(CFG_X_GAIN, 16'h0000);
        write_register(CFG_Y_GAIN, 16'h0001);
        stall_style = 2;
        add_traffic(200);
        settle_then_idle();

        write_register(CFG_REPORT_EN, 16'h0000);
        write_register(CFG_X_GAIN, 16'($urandom));
        write_register(CFG_Y_GAIN, 16'($urandom_range(0, 2000)));
        stall_style = 1;
        add_traffic(200);
        settle_then_idle();

        write_register(CFG_UNUSED, 16'($urandom));
        write_register(CFG_X_GAIN, 16'($urandom_range(1, 3000)));
        write_register(CFG_Y_GAIN, 16'($urandom));
        write_register(CFG_REPORT_EN, 16'hFFFF);
        stall_style = 3;
        add_traffic(175);
        stall_style = 0;
        add_traffic(175);

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ps2_mouse_packet_tracker_test: PASS");
        end
        else
        begin
            $display("ps2_mouse_packet_tracker_test: FAIL");
        end
        $finish;
    end

endmodule
